@@ hdl/serial_fifo_with_crc16_unit_defines.svh @@
// Assertion macros for the serial FIFO with CRC-16 unit.
`ifndef SERIAL_FIFO_WITH_CRC16_UNIT_DEFINES_SVH
`define SERIAL_FIFO_WITH_CRC16_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define SFC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sfc assertion failed");
`define SFC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("sfc assertion failed");
`else
`define SFC_ASSERT(lbl, prop)
`define SFC_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ hdl/sfc_pkg.sv @@
// Shared types, item kind codes and CRC-16 fold for the serial FIFO unit.
package sfc_pkg;

  localparam logic [2:0] KIND_RX_BYTE  = 3'd0;
  localparam logic [2:0] KIND_HOST_RD  = 3'd1;
  localparam logic [2:0] KIND_HOST_WR  = 3'd2;
  localparam logic [2:0] KIND_TX_DONE  = 3'd3;
  localparam logic [2:0] KIND_FLUSH    = 3'd4;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } fifo_cmd_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hdl/sfc_fifo.sv @@
// Byte FIFO with one write and one registered read port, holding DEPTH-1 bytes.
module sfc_fifo
  import sfc_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  fifo_cmd_t     cmd_i,
  input  logic [7:0]    wdata_i,
  output logic [AW-1:0] count_o,
  output logic          full_o,
  output logic          empty_o,
  output logic [7:0]    rdata_o
);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [AW-1:0] head_inc, tail_inc;
  logic [7:0]    rdata_q, wdata_q;
  logic          fwd_q;
  logic          we;

  assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_inc = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;

  assign count_o = (head_q >= tail_q) ? head_q - tail_q
                 : AW'({1'b0, head_q} + (AW + 1)'(DEPTH) - {1'b0, tail_q});
  assign full_o  = (count_o >= AW'(DEPTH - 1));
  assign empty_o = (count_o == '0);
  assign we      = cmd_i.push && !full_o;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (cmd_i.flush) begin
      head_d = '0;
      tail_d = '0;
    end else begin
      if (we) begin
        head_d = head_inc;
      end
      if (cmd_i.pop) begin
        tail_d = tail_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fwd_q  <= 1'b0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fwd_q  <= we && (head_q == tail_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[head_q] <= wdata_i;
    end
    rdata_q <= mem[tail_d];
    wdata_q <= wdata_i;
  end

  assign rdata_o = fwd_q ? wdata_q : rdata_q;

endmodule

@@ hdl/serial_fifo_with_crc16_unit.sv @@
// Top level of the serial front end: receive and transmit FIFOs with running CRC-16.
//
// channel   direction  handshake            payload
// command   in         start_i & !busy_o    kind_i, data_byte_i
// result    out        done_o (one cycle)   read_data_o .. overflow_o
//
// One item per cycle; its result strobes on done_o in the cycle after acceptance.
// Each item is decoded and applied to the FIFOs and CRC registers in the cycle it is accepted.
// busy_o is always low; the FIFO head byte is a registered read of the store.
// Reset clears pointers, busy flag and strobe and sets both CRCs to all ones.
// The receiver cannot stall; results are never held.
`include "serial_fifo_with_crc16_unit_defines.svh"

module serial_fifo_with_crc16_unit
  import sfc_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  data_byte_i,
  output logic        done_o,
  output logic [7:0]  read_data_o,
  output logic        read_valid_o,
  output logic [7:0]  send_byte_o,
  output logic        send_start_o,
  output logic [5:0]  rx_count_o,
  output logic [5:0]  tx_count_o,
  output logic [15:0] crc_rx_o,
  output logic [15:0] crc_tx_o,
  output logic        busy_res_o,
  output logic        overflow_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = (AW > 6) ? AW : 6;

  fifo_cmd_t     rx_cmd, tx_cmd;
  logic [AW-1:0] rx_count, tx_count;
  logic          rx_full, rx_empty, tx_full, tx_empty;
  logic [7:0]    rx_rdata, tx_rdata;
  logic [CW-1:0] rx_count_ext, tx_count_ext;

  logic [15:0]   rx_crc_q, rx_crc_d, tx_crc_q, tx_crc_d;
  logic          tx_busy_q, tx_busy_d;
  logic          done_q;
  logic [7:0]    read_data_q, read_data_d, send_byte_q, send_byte_d;
  logic          read_valid_q, read_valid_d, send_start_q, send_start_d;
  logic          overflow_q, overflow_d;
  logic          accept;
  logic [7:0]    tx_next;

  assign busy_o  = 1'b0;
  assign accept  = start_i && !busy_o;
  assign tx_next = tx_empty ? data_byte_i : tx_rdata;

  always_comb begin
    rx_cmd       = '0;
    tx_cmd       = '0;
    rx_crc_d     = rx_crc_q;
    tx_crc_d     = tx_crc_q;
    tx_busy_d    = tx_busy_q;
    read_data_d  = 8'h00;
    read_valid_d = 1'b0;
    send_byte_d  = 8'h00;
    send_start_d = 1'b0;
    overflow_d   = 1'b0;
    if (accept) begin
      case (kind_i)
        KIND_RX_BYTE: begin
          rx_cmd.push = 1'b1;
          overflow_d  = rx_full;
          rx_crc_d    = crc_fold(rx_crc_q, data_byte_i);
        end
        KIND_HOST_RD: begin
          if (!rx_empty) begin
            rx_cmd.pop   = 1'b1;
            read_data_d  = rx_rdata;
            read_valid_d = 1'b1;
          end
        end
        KIND_HOST_WR: begin
          tx_cmd.push = 1'b1;
          overflow_d  = tx_full;
          if (!tx_busy_q) begin
            tx_cmd.pop   = 1'b1;
            send_byte_d  = tx_next;
            send_start_d = 1'b1;
            tx_busy_d    = 1'b1;
            tx_crc_d     = crc_fold(tx_crc_q, tx_next);
          end
        end
        KIND_TX_DONE: begin
          tx_busy_d = !tx_empty;
          if (!tx_empty) begin
            tx_cmd.pop   = 1'b1;
            send_byte_d  = tx_rdata;
            send_start_d = 1'b1;
            tx_crc_d     = crc_fold(tx_crc_q, tx_rdata);
          end
        end
        KIND_FLUSH: begin
          rx_cmd.flush = 1'b1;
          tx_cmd.flush = 1'b1;
          tx_busy_d    = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_crc_q  <= CRC_INIT;
      tx_crc_q  <= CRC_INIT;
      tx_busy_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      rx_crc_q  <= rx_crc_d;
      tx_crc_q  <= tx_crc_d;
      tx_busy_q <= tx_busy_d;
      done_q    <= accept;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_valid_q <= 1'b0;
      send_start_q <= 1'b0;
      overflow_q   <= 1'b0;
    end else begin
      read_valid_q <= read_valid_d;
      send_start_q <= send_start_d;
      overflow_q   <= overflow_d;
    end
  end

  always_ff @(posedge clk_i) begin
    read_data_q <= read_data_d;
    send_byte_q <= send_byte_d;
  end

  sfc_fifo #(.DEPTH(DEPTH)) u_rx_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (rx_cmd),
    .wdata_i (data_byte_i),
    .count_o (rx_count),
    .full_o  (rx_full),
    .empty_o (rx_empty),
    .rdata_o (rx_rdata)
  );

  sfc_fifo #(.DEPTH(DEPTH)) u_tx_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (tx_cmd),
    .wdata_i (data_byte_i),
    .count_o (tx_count),
    .full_o  (tx_full),
    .empty_o (tx_empty),
    .rdata_o (tx_rdata)
  );

  assign rx_count_ext = CW'(rx_count);
  assign tx_count_ext = CW'(tx_count);

  assign done_o       = done_q;
  assign read_data_o  = read_data_q;
  assign read_valid_o = read_valid_q;
  assign send_byte_o  = send_byte_q;
  assign send_start_o = send_start_q;
  assign rx_count_o   = rx_count_ext[5:0];
  assign tx_count_o   = tx_count_ext[5:0];
  assign crc_rx_o     = rx_crc_q;
  assign crc_tx_o     = tx_crc_q;
  assign busy_res_o   = tx_busy_q;
  assign overflow_o   = overflow_q;

  `SFC_ASSERT(a_done_follows_start, accept |=> done_o)
  `SFC_ASSERT(a_no_spurious_done, !accept |=> !done_o)
  `SFC_ASSERT(a_send_sets_busy, send_start_o |-> busy_res_o)
  `SFC_ASSERT(a_ovf_only_on_push, accept && kind_i != KIND_RX_BYTE && kind_i != KIND_HOST_WR |=> !overflow_o)
  `SFC_ASSERT_ALWAYS(a_read_in_result, read_valid_o |-> done_o)

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the serial FIFO unit with receive and transmit CRC-16.
`timescale 1ns / 100ps

module testbench;
  import sfc_pkg::*;

  localparam logic [2:0] KIND_SPARE_5 = 3'd5;
  localparam logic [2:0] KIND_SPARE_6 = 3'd6;
  localparam logic [2:0] KIND_SPARE_7 = 3'd7;
  localparam int         RANDOM_ITEMS = 1000;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        read_valid;
    logic [7:0]  send_byte;
    logic        send_start;
    logic [5:0]  rx_count;
    logic [5:0]  tx_count;
    logic [15:0] crc_rx;
    logic [15:0] crc_tx;
    logic        busy_res;
    logic        overflow;
  } line_status_t;

  typedef struct {
    logic [2:0] kind;
    logic [7:0] data;
    bit         typed;
  } stim_row_t;

  localparam line_status_t IDLE_STATUS = {8'h00, 1'b0, 8'h00, 1'b0, 6'd0, 6'd0,
                                          CRC_INIT, CRC_INIT, 1'b0, 1'b0};

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [2:0]  kind_i;
  logic [7:0]  data_byte_i;
  logic        done_o;
  logic [7:0]  read_data_o;
  logic        read_valid_o;
  logic [7:0]  send_byte_o;
  logic        send_start_o;
  logic [5:0]  rx_count_o;
  logic [5:0]  tx_count_o;
  logic [15:0] crc_rx_o;
  logic [15:0] crc_tx_o;
  logic        busy_res_o;
  logic        overflow_o;

  logic [7:0]  rx_mem [64];
  logic [7:0]  tx_mem [64];
  logic [5:0]  rx_wr, rx_rd, tx_wr, tx_rd;
  logic        tx_active;
  logic [15:0] rx_crc_q, tx_crc_q;

  line_status_t pending_status [$];
  int           mismatches;
  int           items_done;
  bit           pace_on;

  stim_row_t directed_rows [$] = '{
    '{KIND_HOST_RD, 8'h00, 1'b1},
    '{KIND_TX_DONE, 8'hFF, 1'b1},
    '{KIND_SPARE_5, 8'h55, 1'b1},
    '{KIND_SPARE_6, 8'hAA, 1'b1},
    '{KIND_SPARE_7, 8'hFF, 1'b1},
    '{KIND_FLUSH,   8'h00, 1'b1},
    '{KIND_RX_BYTE, 8'h00, 1'b0},
    '{KIND_RX_BYTE, 8'hFF, 1'b0},
    '{KIND_RX_BYTE, 8'hA5, 1'b0},
    '{KIND_HOST_RD, 8'h00, 1'b0},
    '{KIND_HOST_WR, 8'hFF, 1'b0},
    '{KIND_HOST_WR, 8'h00, 1'b0},
    '{KIND_HOST_WR, 8'h5A, 1'b0},
    '{KIND_TX_DONE, 8'h00, 1'b0},
    '{KIND_SPARE_7, 8'h3C, 1'b0},
    '{KIND_FLUSH,   8'hFF, 1'b0},
    '{KIND_HOST_RD, 8'h00, 1'b0},
    '{KIND_TX_DONE, 8'h00, 1'b0},
    '{KIND_HOST_WR, 8'h80, 1'b0},
    '{KIND_TX_DONE, 8'h00, 1'b0},
    '{KIND_TX_DONE, 8'h00, 1'b0},
    '{KIND_RX_BYTE, 8'h01, 1'b0},
    '{KIND_HOST_RD, 8'h00, 1'b0},
    '{KIND_HOST_RD, 8'h00, 1'b0}
  };

  serial_fifo_with_crc16_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .kind_i       (kind_i),
    .data_byte_i  (data_byte_i),
    .done_o       (done_o),
    .read_data_o  (read_data_o),
    .read_valid_o (read_valid_o),
    .send_byte_o  (send_byte_o),
    .send_start_o (send_start_o),
    .rx_count_o   (rx_count_o),
    .tx_count_o   (tx_count_o),
    .crc_rx_o     (crc_rx_o),
    .crc_tx_o     (crc_tx_o),
    .busy_res_o   (busy_res_o),
    .overflow_o   (overflow_o)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [15:0] crc16_modbus_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] acc;
    acc = crc;
    for (int k = 0; k < 8; k++) begin
      acc = {1'b0, acc[15:1]} ^ ((acc[0] ^ b[k]) ? CRC_POLY : 16'h0000);
    end
    return acc;
  endfunction

  function automatic line_status_t serial_line_step(logic [2:0] kind, logic [7:0] data);
    line_status_t r;
    logic [5:0]   rx_fill, tx_fill;
    r = '0;
    rx_fill = rx_wr - rx_rd;
    tx_fill = tx_wr - tx_rd;
    case (kind)
      KIND_RX_BYTE: begin
        if (rx_fill == 6'd63) begin
          r.overflow = 1'b1;
        end else begin
          rx_mem[rx_wr] = data;
          rx_wr = rx_wr + 6'd1;
        end
        rx_crc_q = crc16_modbus_byte(rx_crc_q, data);
      end
      KIND_HOST_RD: begin
        if (rx_fill != 6'd0) begin
          r.read_data  = rx_mem[rx_rd];
          r.read_valid = 1'b1;
          rx_rd = rx_rd + 6'd1;
        end
      end
      KIND_HOST_WR: begin
        if (tx_fill == 6'd63) begin
          r.overflow = 1'b1;
        end else begin
          tx_mem[tx_wr] = data;
          tx_wr = tx_wr + 6'd1;
        end
      end
      KIND_FLUSH: begin
        rx_wr = '0;
        rx_rd = '0;
        tx_wr = '0;
        tx_rd = '0;
        tx_active = 1'b0;
      end
      default: begin
      end
    endcase
    if (kind == KIND_TX_DONE || (kind == KIND_HOST_WR && !tx_active)) begin
      if (tx_wr != tx_rd) begin
        r.send_byte  = tx_mem[tx_rd];
        r.send_start = 1'b1;
        tx_crc_q = crc16_modbus_byte(tx_crc_q, tx_mem[tx_rd]);
        tx_rd = tx_rd + 6'd1;
        tx_active = 1'b1;
      end else begin
        tx_active = 1'b0;
      end
    end
    r.rx_count = rx_wr - rx_rd;
    r.tx_count = tx_wr - tx_rd;
    r.crc_rx   = rx_crc_q;
    r.crc_tx   = tx_crc_q;
    r.busy_res = tx_active;
    return r;
  endfunction

  task automatic issue(input logic [2:0] kind, input logic [7:0] data, input bit typed);
    int           gap;
    line_status_t want;
    gap = pace_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      start_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i     = 1'b1;
    kind_i      = kind;
    data_byte_i = data;
    do @(posedge clk_i); while (busy_o);
    want = serial_line_step(kind, data);
    pending_status.push_back(typed ? IDLE_STATUS : want);
    if (kind <= KIND_FLUSH) items_done++;
  endtask

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    line_status_t want;
    if (rst_ni && done_o) begin
      if (pending_status.size() == 0) begin
        $display("%0t: result with no item outstanding", $time);
        mismatches++;
      end else begin
        want = pending_status.pop_front();
        check_field("read_data", want.read_data, read_data_o);
        check_field("read_valid", want.read_valid, read_valid_o);
        check_field("send_byte", want.send_byte, send_byte_o);
        check_field("send_start", want.send_start, send_start_o);
        check_field("rx_count", want.rx_count, rx_count_o);
        check_field("tx_count", want.tx_count, tx_count_o);
        check_field("crc_rx", want.crc_rx, crc_rx_o);
        check_field("crc_tx", want.crc_tx, crc_tx_o);
        check_field("busy_res", want.busy_res, busy_res_o);
        check_field("overflow", want.overflow, overflow_o);
      end
    end
  end

  initial begin
    int         mode;
    int         len;
    int         r;
    int         waited;
    logic [2:0] pick;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    kind_i      = KIND_RX_BYTE;
    data_byte_i = 8'h00;
    pace_on     = 1'b0;
    mismatches  = 0;
    items_done  = 0;
    rx_wr       = '0;
    rx_rd       = '0;
    tx_wr       = '0;
    tx_rd       = '0;
    tx_active   = 1'b0;
    rx_crc_q    = CRC_INIT;
    tx_crc_q    = CRC_INIT;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      pace_on = 1'($urandom_range(0, 1));
      issue(directed_rows[i].kind, directed_rows[i].data, directed_rows[i].typed);
    end

    items_done = 0;
    while (items_done < RANDOM_ITEMS) begin
      mode    = $urandom_range(0, 9);
      pace_on = ($urandom_range(0, 2) != 0);
      case (mode)
        0, 1, 2: begin
          repeat ($urandom_range(1, 16)) begin
            r = $urandom_range(0, 19);
            if (r == 0) pick = KIND_FLUSH;
            else if (r == 1) pick = 3'($urandom_range(5, 7));
            else pick = 3'($urandom_range(0, 3));
            issue(pick, 8'($urandom_range(0, 255)), 1'b0);
          end
        end
        3: begin
          repeat ($urandom_range(60, 72)) begin
            issue(KIND_RX_BYTE, 8'($urandom_range(0, 255)), 1'b0);
          end
        end
        4: begin
          repeat ($urandom_range(60, 72)) begin
            issue(KIND_HOST_WR, 8'($urandom_range(0, 255)), 1'b0);
          end
        end
        5, 6: begin
          len = $urandom_range(1, 8);
          repeat (len) issue(KIND_RX_BYTE, 8'($urandom_range(0, 255)), 1'b0);
          repeat (len + 1) issue(KIND_HOST_RD, 8'($urandom_range(0, 255)), 1'b0);
        end
        7, 8: begin
          len = $urandom_range(1, 8);
          repeat (len) issue(KIND_HOST_WR, 8'($urandom_range(0, 255)), 1'b0);
          repeat (len + 1) issue(KIND_TX_DONE, 8'($urandom_range(0, 255)), 1'b0);
        end
        default: begin
          repeat ($urandom_range(1, 70)) begin
            pick = $urandom_range(0, 1) ? KIND_HOST_RD : KIND_TX_DONE;
            issue(pick, 8'($urandom_range(0, 255)), 1'b0);
          end
        end
      endcase
    end

    @(negedge clk_i);
    start_i = 1'b0;
    waited = 0;
    while (pending_status.size() != 0 && waited < 100) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
    if (pending_status.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_status.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: run timed out", $time);
    $display("testbench: done, errors");
    $finish;
  end

endmodule
